[rtl/fpq_alu_pkg.sv]
// Shared types and operation codes for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
package fpq_alu_pkg;

    // Operation codes carried in the mode field
    localparam logic [3:0] MODE_ADD  = 4'd0;
    localparam logic [3:0] MODE_SUB  = 4'd1;
    localparam logic [3:0] MODE_MUL  = 4'd2;
    localparam logic [3:0] MODE_DIV  = 4'd3;
    localparam logic [3:0] MODE_MIN  = 4'd4;
    localparam logic [3:0] MODE_MAX  = 4'd5;
    localparam logic [3:0] MODE_INC  = 4'd6;
    localparam logic [3:0] MODE_DEC  = 4'd7;
    localparam logic [3:0] MODE_ITOF = 4'd8;
    localparam logic [3:0] MODE_FTOI = 4'd9;

    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] a_raw;
        logic signed [31:0] b_raw;
    } fpq_in_t;

    typedef struct packed {
        logic signed [31:0] result_raw;
        logic               a_less;
        logic               a_greater;
        logic               a_equal;
        logic               overflowed;
        logic               divide_by_zero;
    } fpq_out_t;

endpackage

[rtl/fixed_point_q24_8_alu.sv]
// Pipelined signed fixed-point ALU: add, sub, inc, dec, mul, div, min, max and conversions.
`timescale 1ns / 1ps
// One operation enters per clock on start (busy is always low) and its result
// appears on rsp, marked by a one-cycle done strobe, once it has passed stage 0,
// the multiply and rounding stages, the restoring divider that retires one
// quotient bit per stage across 33 stages, and the output register; the delay
// does not depend on FRAC_BITS. Results leave in the order items entered; the
// receiver cannot stall and must take each result in its strobe cycle. Multiply
// and divide round half away from zero; out-of-range results saturate with overflowed set.
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fpq_alu_pkg::fpq_in_t req,
    output logic                 done,
    output fpq_alu_pkg::fpq_out_t rsp
);
    import fpq_alu_pkg::*;

    localparam int QW    = 33;              // quotient bits before saturation
    localparam int DW    = 33;              // doubled divisor width
    localparam int NW    = 34 + FRAC_BITS;  // doubled, rounded dividend width
    localparam int DEPTH = 3 + QW;

    typedef struct packed {
        logic [3:0]         mode;
        logic               neg;
        logic               dz;
        logic               lt;
        logic               gt;
        logic               eq;
        logic signed [31:0] r;
        logic               ovf;
        logic [31:0]        mag_a;
        logic [31:0]        mag_b;
        logic [63:0]        prod;
        logic [NW-1:0]      rem;
        logic [DW-1:0]      den;
        logic [QW-1:0]      quo;
        logic               div_big;
    } pipe_t;

    // Apply a sign to a magnitude, saturating to the word range; returns {ovf, r}
    function automatic logic [32:0] sign_mag(input logic [64:0] mag, input logic neg);
        logic [64:0] nmag;
        logic [32:0] res;
        nmag = -mag;
        if (neg) begin
            if (mag > 65'h0_8000_0000) res = {1'b1, WORD_MIN};
            else                       res = {1'b0, nmag[31:0]};
        end else begin
            if (mag > 65'h0_7FFF_FFFF) res = {1'b1, WORD_MAX};
            else                       res = {1'b0, mag[31:0]};
        end
        return res;
    endfunction

    // Saturate a 33-bit signed sum to the word range; returns {ovf, r}
    function automatic logic [32:0] clamp33(input logic [32:0] s);
        logic [32:0] res;
        if (s[32] != s[31]) res = {1'b1, (s[32] ? WORD_MIN : WORD_MAX)};
        else                res = {1'b0, s[31:0]};
        return res;
    endfunction

    pipe_t pipe_reg  [DEPTH];
    pipe_t pipe_next [DEPTH];
    logic  valid_reg [DEPTH];
    logic  done_reg;
    fpq_out_t rsp_reg;
    fpq_out_t rsp_next;

    logic signed [31:0]        a;
    logic signed [31:0]        b;
    logic [32:0]               s_add;
    logic [32:0]               s_sub;
    logic [32:0]               s_inc;
    logic [32:0]               s_dec;
    logic signed [31+FRAC_BITS:0] itof;
    logic [32:0]               ftoi_t;
    logic [32:0]               ftoi_s;
    logic [NW-1:0]             n0;
    logic [64:0]               mul_m;
    logic [32:0]               mul_sm;
    logic [32:0]               div_sm;

    assign busy = 1'b0;
    assign a    = req.a_raw;
    assign b    = req.b_raw;

    // Stage 0: decode, compare, simple operations and divider setup
    always_comb
    begin
        pipe_t p;
        p         = '0;
        p.mode    = req.mode;
        p.lt      = a < b;
        p.gt      = a > b;
        p.eq      = a == b;
        p.neg     = a[31] ^ b[31];
        p.mag_a   = a[31] ? (32'd0 - a) : a;
        p.mag_b   = b[31] ? (32'd0 - b) : b;
        p.den     = {p.mag_b, 1'b0};
        n0        = {1'b0, p.mag_a, {FRAC_BITS{1'b0}}, 1'b0} + NW'(p.mag_b);
        p.rem     = n0;
        p.div_big = (NW'(n0 >> QW)) >= NW'(p.den);
        p.dz      = (req.mode == MODE_DIV) && (b == 32'sd0);

        s_add  = {a[31], a} + {b[31], b};
        s_sub  = {a[31], a} - {b[31], b};
        s_inc  = {a[31], a} + 33'd1;
        s_dec  = {a[31], a} - 33'd1;
        itof   = {a, {FRAC_BITS{1'b0}}};
        ftoi_t = {a[31], a} + (a[31] ? 33'((1 << FRAC_BITS) - 1) : 33'd0);
        ftoi_s = 33'($signed(ftoi_t) >>> FRAC_BITS);

        p.r   = 32'sd0;
        p.ovf = 1'b0;
        unique case (req.mode)
            MODE_ADD: {p.ovf, p.r} = clamp33(s_add);
            MODE_SUB: {p.ovf, p.r} = clamp33(s_sub);
            MODE_INC: {p.ovf, p.r} = clamp33(s_inc);
            MODE_DEC: {p.ovf, p.r} = clamp33(s_dec);
            MODE_MIN: p.r = (a < b) ? a : b;
            MODE_MAX: p.r = (a > b) ? a : b;
            MODE_ITOF:
            begin
                if (itof[31+FRAC_BITS:31] != {(FRAC_BITS+1){itof[31+FRAC_BITS]}})
                begin
                    p.ovf = 1'b1;
                    p.r   = itof[31+FRAC_BITS] ? WORD_MIN : WORD_MAX;
                end
                else
                begin
                    p.r = itof[31:0];
                end
            end
            MODE_FTOI: p.r = ftoi_s[31:0];
            MODE_DIV:
            begin
                if (p.dz)
                begin
                    p.ovf = 1'b1;
                    p.r   = a[31] ? WORD_MIN : WORD_MAX;
                end
            end
            default: p.r = 32'sd0;
        endcase
        pipe_next[0] = p;
    end

    // Stage 1: multiply magnitudes
    always_comb
    begin
        pipe_next[1]      = pipe_reg[0];
        pipe_next[1].prod = 64'(pipe_reg[0].mag_a) * 64'(pipe_reg[0].mag_b);
    end

    // Stage 2: round and saturate the product
    always_comb
    begin
        pipe_next[2] = pipe_reg[1];
        mul_m  = ({1'b0, pipe_reg[1].prod} + 65'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        mul_sm = sign_mag(mul_m, pipe_reg[1].neg);
        if (pipe_reg[1].mode == MODE_MUL)
        begin
            {pipe_next[2].ovf, pipe_next[2].r} = mul_sm;
        end
    end

    // Divider stages: retire one quotient bit each, most significant first
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int BIT = QW - 1 - k;
        always_comb
        begin
            pipe_next[3+k] = pipe_reg[2+k];
            if ((pipe_reg[2+k].rem >> BIT) >= NW'(pipe_reg[2+k].den))
            begin
                pipe_next[3+k].rem      = pipe_reg[2+k].rem - (NW'(pipe_reg[2+k].den) << BIT);
                pipe_next[3+k].quo[BIT] = 1'b1;
            end
        end
    end

    // Output stage: sign the quotient and assemble the result
    always_comb
    begin
        div_sm = sign_mag(pipe_reg[DEPTH-1].div_big ? {65{1'b1}} : 65'(pipe_reg[DEPTH-1].quo),
                          pipe_reg[DEPTH-1].neg);
        rsp_next.result_raw     = pipe_reg[DEPTH-1].r;
        rsp_next.overflowed     = pipe_reg[DEPTH-1].ovf;
        rsp_next.a_less         = pipe_reg[DEPTH-1].lt;
        rsp_next.a_greater      = pipe_reg[DEPTH-1].gt;
        rsp_next.a_equal        = pipe_reg[DEPTH-1].eq;
        rsp_next.divide_by_zero = pipe_reg[DEPTH-1].dz;
        if (pipe_reg[DEPTH-1].mode == MODE_DIV && !pipe_reg[DEPTH-1].dz)
        begin
            {rsp_next.overflowed, rsp_next.result_raw} = div_sm;
        end
    end

    // Advance valid bits with each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++) valid_reg[i] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start && !busy;
            for (int i = 1; i < DEPTH; i++) valid_reg[i] <= valid_reg[i-1];
            done_reg <= valid_reg[DEPTH-1];
        end
    end

    // Advance payload; no reset needed
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++) pipe_reg[i] <= pipe_next[i];
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
